### hdl/mlfc_pkg.sv
// Shared types and constants for the magnetic line frame centroid block.
// Used by the frame parser, the iterative divider and the top level.
package mlfc_pkg;

  localparam int BYTE_W         = 8;
  localparam int PAT_W          = 16;
  localparam int CNT_W          = 5;
  localparam int SUM_W          = 8;
  localparam int DEV_W          = 12;
  localparam int IDX_W          = 4;
  localparam int SCAN_W         = 4;
  localparam int FRAC_BITS_DEF  = 8;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h01;

  // Frame position codes, start byte counted as position one
  localparam logic [IDX_W-1:0] IDX_FIRST    = 4'd1;
  localparam logic [IDX_W-1:0] IDX_FOURTH   = 4'd3;
  localparam logic [IDX_W-1:0] IDX_FIFTH    = 4'd4;
  localparam logic [IDX_W-1:0] IDX_COMPLETE = 4'd7;
  localparam logic [IDX_W-1:0] IDX_SAT      = 4'd8;

  localparam int DEV_MAX = 2047;
  localparam int DEV_MIN = -2048;

  // Frame parser to sequencer: a complete frame and its pattern
  typedef struct packed {
    logic             launch;
    logic [PAT_W-1:0] pattern;
  } frame_evt_t;

endpackage

### hdl/mlfc_frame.sv
// Frame parser: holds the start byte register, counts bytes since the last
// start byte and captures the two pattern bytes. Depends on mlfc_pkg.
module mlfc_frame
  import mlfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [BYTE_W-1:0] cfg_data,
  input  logic              rx_accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output frame_evt_t        evt
);

  logic [BYTE_W-1:0] start_byte;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] fourth_byte;
  logic [BYTE_W-1:0] fifth_byte;
  logic              is_start;

  assign is_start    = (rx_byte == start_byte);
  assign evt.launch  = rx_accept && is_start && (byte_index == IDX_COMPLETE);
  assign evt.pattern = {fourth_byte, fifth_byte};

  // Hold the start byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
    end else if (cfg_valid) begin
      start_byte <= cfg_data;
    end
  end

  // Advance the byte position, capture data bytes, restart on a start byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= IDX_FIRST;
      fourth_byte <= '0;
      fifth_byte  <= '0;
    end else if (rx_accept) begin
      if (is_start) begin
        byte_index  <= IDX_FIRST;
        fourth_byte <= '0;
        fifth_byte  <= '0;
      end else begin
        if (byte_index == IDX_FOURTH) begin
          fourth_byte <= rx_byte;
        end else if (byte_index == IDX_FIFTH) begin
          fifth_byte <= rx_byte;
        end
        if (byte_index < IDX_SAT) begin
          byte_index <= byte_index + IDX_W'(1);
        end
      end
    end
  end

endmodule

### hdl/mlfc_divu.sv
// Restoring unsigned divider, one quotient bit per cycle through a single
// compare and subtract unit. Depends on mlfc_pkg for the divisor width.
module mlfc_divu
  import mlfc_pkg::*;
#(
  parameter int DIVIDEND_W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [CNT_W-1:0]      divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DIVIDEND_W-1:0] acc;
  logic [CNT_W-1:0]      rem;
  logic [CNT_W-1:0]      dsr;
  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        diff;
  logic                  fits;

  // Shared compare and subtract
  assign trial    = {rem, acc[DIVIDEND_W-1]};
  assign fits     = (trial >= {1'b0, dsr});
  assign diff     = trial - {1'b0, dsr};
  assign quotient = acc;

  // Control: busy window and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      acc <= {acc[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

endmodule

### hdl/magnetic_line_frame_centroid.sv
// Top level of the magnetic line frame centroid block: sequencer, bit scan,
// divider and result register. Depends on mlfc_pkg, mlfc_frame, mlfc_divu.
//
// Usage:
//   rx channel (rx_valid/rx_ready, rx_byte) carries received UART bytes.
//   res channel (res_valid/res_ready) carries one result per complete frame:
//   line_deviation, active_count, sensor_pattern, no_line.
//   cfg channel (cfg_valid/cfg_ready, cfg_data) writes the start byte; it is
//   always ready and is to be written only while the block is idle.
// Timing:
//   A byte that does not complete a frame is taken and rx_ready stays
//   high. A start byte that closes a six-byte frame drops rx_ready for the
//   bit scan, the divider start, the divider run, the capture of the
//   quotient and the load of the result register. With no active point
//   the divider is skipped.
// Reset: the start byte returns to 0x01, the frame position to the start,
//   the captured bytes to zero, and no result is pending.
// Stall: a result waits in the output register while res_ready is low;
//   bytes are still taken, but a further complete frame holds its result
//   and keeps rx_ready low until the register is free.
module magnetic_line_frame_centroid
  import mlfc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [BYTE_W-1:0]       cfg_data,
  input  logic                    rx_valid,
  output logic                    rx_ready,
  input  logic [BYTE_W-1:0]       rx_byte,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic signed [DEV_W-1:0] line_deviation,
  output logic [CNT_W-1:0]        active_count,
  output logic [PAT_W-1:0]        sensor_pattern,
  output logic                    no_line
);

  localparam int QW     = SUM_W + FRAC_BITS;
  localparam int OFFSET = 17 << (FRAC_BITS - 1);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(PAT_W - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_DONE} state_t;

  state_t              state;
  frame_evt_t          evt;
  logic [PAT_W-1:0]    pattern;
  logic [PAT_W-1:0]    scan_bits;
  logic [SCAN_W-1:0]   step;
  logic [CNT_W-1:0]    count;
  logic [SUM_W-1:0]    sum_pos;
  logic [DEV_W-1:0]    dev;
  logic                div_start;
  logic                div_done;
  logic [QW-1:0]       quot;
  logic [CNT_W-1:0]    cnt_add;
  logic [SUM_W-1:0]    sum_add;
  logic signed [QW+1:0] dev_wide;
  logic [DEV_W-1:0]    dev_sat;

  assign cfg_ready = 1'b1;
  assign rx_ready  = (state == S_IDLE);

  mlfc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .rx_accept (rx_valid && rx_ready),
    .rx_byte   (rx_byte),
    .evt       (evt)
  );

  mlfc_divu #(
    .DIVIDEND_W (QW)
  ) u_divu (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_pos, {FRAC_BITS{1'b0}}}),
    .divisor  (count),
    .done     (div_done),
    .quotient (quot)
  );

  // Scan step: add one point and its position
  assign cnt_add = count + CNT_W'(scan_bits[0]);
  assign sum_add = sum_pos + (scan_bits[0] ? (SUM_W'(step) + SUM_W'(1)) : SUM_W'(0));

  // Remove the centre offset and clamp to the output range
  assign dev_wide = $signed({2'b00, quot}) - $signed((QW+2)'(OFFSET));
  always_comb begin
    if (dev_wide > $signed((QW+2)'(DEV_MAX))) begin
      dev_sat = DEV_W'(DEV_MAX);
    end else if (dev_wide < $signed((QW+2)'(DEV_MIN))) begin
      dev_sat = DEV_W'(DEV_MIN);
    end else begin
      dev_sat = dev_wide[DEV_W-1:0];
    end
  end

  // Sequencer with its control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (evt.launch) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step == SCAN_LAST) begin
            if (cnt_add == '0) begin
              state <= S_DONE;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: scan, deviation and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (evt.launch) begin
          pattern   <= evt.pattern;
          scan_bits <= evt.pattern;
          step      <= '0;
          count     <= '0;
          sum_pos   <= '0;
        end
      end
      S_SCAN: begin
        count     <= cnt_add;
        sum_pos   <= sum_add;
        scan_bits <= scan_bits >> 1;
        step      <= step + SCAN_W'(1);
        dev       <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          dev <= dev_sat;
        end
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          line_deviation <= $signed(dev);
          active_count   <= count;
          sensor_pattern <= pattern;
          no_line        <= (count == '0);
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_launch_when_idle: assert property (@(posedge clk) disable iff (rst)
    evt.launch |-> state == S_IDLE)
    else $error("frame launched while sequencer busy");

  a_count_matches_pattern: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $countones(sensor_pattern) == active_count)
    else $error("active count disagrees with pattern");

  a_no_line_zero_dev: assert property (@(posedge clk) disable iff (rst)
    res_valid && no_line |-> line_deviation == '0 && active_count == '0)
    else $error("no_line result carries a deviation");

  a_div_only_with_points: assert property (@(posedge clk) disable iff (rst)
    div_start |-> count != '0)
    else $error("divider started with zero divisor");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for magnetic_line_frame_centroid: drives received bytes,
// predicts each frame's pattern, point count and centroid deviation, and checks results.
// Depends on mlfc_pkg and the magnetic_line_frame_centroid RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mlfc_pkg::*;

  localparam int FRAC              = FRAC_BITS_DEF;
  localparam int HALF_PITCH_OFFSET = 17 << (FRAC - 1);
  localparam int DRAIN_CYCLES      = 64;
  localparam int PHASE_ITEMS       = 300;
  localparam int HOLD_OFF_CYCLES   = 500;
  localparam int MAX_REPORTS       = 10;
  localparam int CYCLE_LIMIT       = 1000000;

  typedef struct packed {
    logic signed [DEV_W-1:0] deviation;
    logic [CNT_W-1:0]        count;
    logic [PAT_W-1:0]        pattern;
    logic                    no_line;
  } centroid_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [BYTE_W-1:0]       cfg_data = '0;
  logic                    rx_valid = 1'b0;
  logic                    rx_ready;
  logic [BYTE_W-1:0]       rx_byte = '0;
  logic                    res_valid;
  logic                    res_ready = 1'b0;
  logic signed [DEV_W-1:0] line_deviation;
  logic [CNT_W-1:0]        active_count;
  logic [PAT_W-1:0]        sensor_pattern;
  logic                    no_line;

  // Frame tracking state mirrored from the block
  logic [BYTE_W-1:0] start_byte = START_BYTE_RST;
  logic [IDX_W-1:0]  frame_pos  = IDX_FIRST;
  logic [BYTE_W-1:0] hi_byte    = '0;
  logic [BYTE_W-1:0] lo_byte    = '0;

  logic [BYTE_W-1:0] rx_pending[$];
  centroid_t         pending_centroids[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int calm_left      = 0;
  int hold_off_left  = 0;
  bit hold_sender    = 1'b0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int pushed_total   = 0;

  magnetic_line_frame_centroid #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .rx_valid      (rx_valid),
    .rx_ready      (rx_ready),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .line_deviation(line_deviation),
    .active_count  (active_count),
    .sensor_pattern(sensor_pattern),
    .no_line       (no_line)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the frame tracker by one accepted byte; queue a centroid when a
  // start byte closes a six-byte frame
  function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
    centroid_t        res;
    logic [PAT_W-1:0] pat;
    int               n;
    int               pos_sum;
    int               dev;
    if (b != start_byte) begin
      if (frame_pos == IDX_FOURTH) begin
        hi_byte = b;
      end else if (frame_pos == IDX_FIFTH) begin
        lo_byte = b;
      end
      if (frame_pos < IDX_SAT) begin
        frame_pos = frame_pos + 1'b1;
      end
    end else begin
      pat = {hi_byte, lo_byte};
      if (frame_pos == IDX_COMPLETE) begin
        n       = 0;
        pos_sum = 0;
        dev     = 0;
        for (int k = 0; k < PAT_W; k++) begin
          if (pat[k]) begin
            n++;
            pos_sum += k + 1;
          end
        end
        // mean position minus 8.5, quotient truncated; no line gives zero
        if (n != 0) begin
          dev = ((pos_sum << FRAC) / n) - HALF_PITCH_OFFSET;
          if (dev > DEV_MAX) dev = DEV_MAX;
          if (dev < DEV_MIN) dev = DEV_MIN;
        end
        res.deviation = dev[DEV_W-1:0];
        res.count     = n[CNT_W-1:0];
        res.pattern   = pat;
        res.no_line   = (n == 0);
        pending_centroids.push_back(res);
      end
      frame_pos = IDX_FIRST;
      hi_byte   = '0;
      lo_byte   = '0;
    end
  endfunction

  function automatic void push_rx(input logic [BYTE_W-1:0] b);
    rx_pending.push_back(b);
    pushed_total++;
  endfunction

  function automatic logic [BYTE_W-1:0] other_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(255)); while (b == start_byte);
    return b;
  endfunction

  // Mix of random, single-point, empty, full and narrow-line patterns
  function automatic logic [PAT_W-1:0] pick_pattern();
    logic [PAT_W-1:0] p;
    int               width;
    case ($urandom_range(7))
      0, 1: p = 16'($urandom());
      2, 3: p = 16'(1) << $urandom_range(15);
      4: p = '0;
      5: p = '1;
      default: begin
        width = $urandom_range(4, 1);
        p     = 16'(((1 << width) - 1) << $urandom_range(15));
      end
    endcase
    return p;
  endfunction

  // Queue a well-formed frame: start byte, two fillers, pattern bytes, two fillers
  function automatic void queue_frame(input logic [PAT_W-1:0] pat);
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    hi = pat[PAT_W-1 -: BYTE_W];
    lo = pat[BYTE_W-1:0];
    // a data byte equal to the start byte would close the frame early
    if (hi == start_byte) hi[0] = ~hi[0];
    if (lo == start_byte) lo[0] = ~lo[0];
    push_rx(start_byte);
    push_rx(other_byte());
    push_rx(other_byte());
    push_rx(hi);
    push_rx(lo);
    push_rx(other_byte());
    push_rx(other_byte());
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (rx_pending.size() != 0 || rx_valid || pending_centroids.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_start_byte(input logic [BYTE_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    start_byte = value;
  endtask

  // Fill one phase: mostly good frames, some wrong-length frames, some noise
  task automatic fill_phase(input int n, input int send_pct, input int stall_pct);
    int first;
    int k;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    first          = pushed_total;
    while (pushed_total - first < n) begin
      case ($urandom_range(9))
        8: begin
          k = $urandom_range(12);
          if (k == 6) k = 7;
          push_rx(start_byte);
          repeat (k) push_rx(other_byte());
        end
        9: begin
          repeat ($urandom_range(8, 1)) begin
            push_rx($urandom_range(3) == 0 ? start_byte : 8'($urandom_range(255)));
          end
        end
        default: queue_frame(pick_pattern());
      endcase
    end
  endtask

  // Drive rx: hold a transaction until taken, then offer the next or idle
  always @(posedge clk) begin : drive_rx
    bit idle_now;
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && rx_ready) track_rx_byte(rx_byte);
      if (!rx_valid || rx_ready) begin
        idle_now = hold_sender || rx_pending.size() == 0 ||
                   (calm_left == 0 && $urandom_range(99) < send_idle_pct);
        if (idle_now) begin
          rx_valid <= 1'b0;
        end else begin
          rx_valid <= 1'b1;
          rx_byte  <= rx_pending.pop_front();
        end
      end
    end
  end

  // Stall the result channel at random, or fully during a hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= (hold_off_left == 0) &&
                   (calm_left != 0 || $urandom_range(99) >= recv_stall_pct);
    end
  end

  // Open occasional stretches with no idling on either side
  always @(posedge clk) begin
    if (rst) begin
      calm_left <= 0;
    end else if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(255) == 0) begin
      calm_left <= $urandom_range(64, 16);
    end
  end

  always @(posedge clk) begin
    if (hold_off_left != 0) hold_off_left <= hold_off_left - 1;
  end

  // Compare each result transaction with the oldest predicted centroid
  always @(posedge clk) begin : check_res
    centroid_t got;
    centroid_t want;
    if (!rst && res_valid && res_ready) begin
      got = '{line_deviation, active_count, sensor_pattern, no_line};
      if (pending_centroids.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected result: dev %0d count %0d pattern %h no_line %0b",
                   got.deviation, got.count, got.pattern, got.no_line);
        end
        mismatch_count++;
      end else begin
        want = pending_centroids.pop_front();
        if (got.deviation !== want.deviation || got.count !== want.count ||
            got.pattern !== want.pattern || got.no_line !== want.no_line) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch: expected dev %0d count %0d pattern %h no_line %0b",
                     want.deviation, want.count, want.pattern, want.no_line);
            $display("          actual   dev %0d count %0d pattern %h no_line %0b",
                     got.deviation, got.count, got.pattern, got.no_line);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("magnetic_line_frame_centroid test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] directed_bytes[];
    directed_bytes = '{
      // full pattern straight out of reset, no leading start byte
      8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01,
      // no active point
      8'hFE, 8'h7F, 8'h00, 8'h00, 8'h55, 8'hAA, 8'h01,
      // short frame
      8'h10, 8'h01,
      // long frame, frame position saturates
      8'h80, 8'h40, 8'hF0, 8'h0F, 8'h20, 8'h02, 8'hC0, 8'h03, 8'h04, 8'h01,
      // last point only, largest deviation
      8'h33, 8'hCC, 8'h80, 8'h00, 8'h11, 8'h22, 8'h01
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed frames at the reset start byte
    @(negedge clk);
    foreach (directed_bytes[i]) push_rx(directed_bytes[i]);

    // no idling, lowest start byte
    write_start_byte(8'h00);
    fill_phase(PHASE_ITEMS, 0, 0);

    // long receiver hold-off while frames keep coming, so the input stalls
    write_start_byte(8'($urandom_range(255)));
    @(negedge clk);
    repeat (10) queue_frame(pick_pattern());
    hold_off_left = HOLD_OFF_CYCLES;

    // sender idling, highest start byte, with a pause until all results drain
    write_start_byte(8'hFF);
    fill_phase(PHASE_ITEMS, 74, 0);
    do @(negedge clk); while (rx_pending.size() > PHASE_ITEMS / 2);
    hold_sender = 1'b1;
    do @(negedge clk); while (rx_valid || pending_centroids.size() != 0);
    hold_sender = 1'b0;

    // receiver stalling
    write_start_byte(8'($urandom_range(255)));
    fill_phase(PHASE_ITEMS, 0, 74);

    // light idling on both sides, back to the reset start byte
    write_start_byte(START_BYTE_RST);
    fill_phase(PHASE_ITEMS, 11, 11);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("magnetic_line_frame_centroid test passed");
    end else begin
      $display("magnetic_line_frame_centroid test failed");
    end
    $finish;
  end

endmodule
